// ===== hdl/kwt_pkg.sv =====
// Shared constants, types and character helpers for the keyword trie block.
package kwt_pkg;

  // Default sizes.
  localparam int unsigned MaxNodesDef   = 512;
  localparam int unsigned CategoriesDef = 13;
  localparam int unsigned AlphabetSize  = 256;

  // Field widths fixed by the interface.
  localparam int unsigned ChW   = 8;
  localparam int unsigned CatW  = 4;
  localparam int unsigned LenW  = 9;
  localparam logic [LenW-1:0] LenCap = 9'd511;

  // Character bounds.
  localparam logic [ChW-1:0] ChUpA  = 8'h41;
  localparam logic [ChW-1:0] ChUpZ  = 8'h5A;
  localparam logic [ChW-1:0] ChLowA = 8'h61;
  localparam logic [ChW-1:0] ChLowZ = 8'h7A;
  localparam logic [ChW-1:0] ChDig0 = 8'h30;
  localparam logic [ChW-1:0] ChDig9 = 8'h39;

  // Request kinds.
  localparam logic KindInsert = 1'b0;
  localparam logic KindText   = 1'b1;

  // Memory port controls between the sequencer and the tables.
  typedef struct packed {
    logic child_re;
    logic child_we;
    logic node_re;
    logic node_we;
  } kwt_mem_ctl_t;

  // Fold an upper-case ASCII letter to lower case.
  function automatic logic [ChW-1:0] fold_lower(input logic [ChW-1:0] c);
    logic [ChW-1:0] r;
    r = c;
    if (c >= ChUpA && c <= ChUpZ) begin
      r = c + (ChLowA - ChUpA);
    end
    return r;
  endfunction

  // True for an ASCII letter or digit.
  function automatic logic is_word(input logic [ChW-1:0] c);
    return (c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ) ||
           (c >= ChDig0 && c <= ChDig9);
  endfunction

endpackage

// ===== hdl/kwt_if.sv =====
// Request and result channel interfaces of the keyword trie block.
interface kwt_in_if;
  import kwt_pkg::*;
  logic            valid;
  logic            ready;
  logic            kind;
  logic [ChW-1:0]  ch;
  logic [CatW-1:0] category;
  logic            last;

  modport source (output valid, kind, ch, category, last, input ready);
  modport sink   (input valid, kind, ch, category, last, output ready);
endinterface

interface kwt_out_if;
  import kwt_pkg::*;
  logic            valid;
  logic            ready;
  logic            result_kind;
  logic            found;
  logic [LenW-1:0] match_length;
  logic [CatW-1:0] match_category;
  logic            table_full;

  modport source (output valid, result_kind, found, match_length, match_category, table_full,
                  input ready);
  modport sink   (input valid, result_kind, found, match_length, match_category, table_full,
                  output ready);
endinterface

// ===== hdl/kwt_tables.sv =====
// Child table and node record memories, both with registered read data.
module kwt_tables
  import kwt_pkg::*;
#(
  parameter int unsigned MAX_NODES = MaxNodesDef,
  parameter int unsigned NODE_W    = $clog2(MAX_NODES),
  parameter int unsigned SLOT_W    = NODE_W + ChW,
  parameter int unsigned REC_W     = SLOT_W + CatW
) (
  input  logic              clk_i,
  input  kwt_mem_ctl_t      ctl_i,
  input  logic [SLOT_W-1:0] child_addr_i,
  input  logic [NODE_W-1:0] child_wdata_i,
  output logic [NODE_W-1:0] child_rdata_o,
  input  logic [NODE_W-1:0] node_raddr_i,
  input  logic [NODE_W-1:0] node_waddr_i,
  input  logic [REC_W-1:0]  node_wdata_i,
  output logic [REC_W-1:0]  node_rdata_o
);

  localparam int unsigned ChildDepth = MAX_NODES * AlphabetSize;

  logic [NODE_W-1:0] child_mem [ChildDepth];
  logic [REC_W-1:0]  node_mem  [MAX_NODES];

  // Child table: one node id per (parent node, character).
  always_ff @(posedge clk_i) begin
    if (ctl_i.child_we) begin
      child_mem[child_addr_i] <= child_wdata_i;
    end
    if (ctl_i.child_re) begin
      child_rdata_o <= child_mem[child_addr_i];
    end
  end

  // Node records: the parent slot that owns the node, and its terminal code.
  always_ff @(posedge clk_i) begin
    if (ctl_i.node_we) begin
      node_mem[node_waddr_i] <= node_wdata_i;
    end
    if (ctl_i.node_re) begin
      node_rdata_o <= node_mem[node_raddr_i];
    end
  end

endmodule

// ===== hdl/keyword_trie_longest_match_top.sv =====
// Keyword trie with case-insensitive insert and bounded longest-match lookup.
// A request passes a child read, a node record read and an update; a byte that a
// dropped keyword or a finished text skips needs no memory read. One request waits in an input
// register; the result is registered at the update, which stalls while it is still held.
// Reset is asynchronous; the memories are not swept: a child counts only if its node id
// lies below the fill count and the node's record names that child's slot back.
module keyword_trie_longest_match_top
  import kwt_pkg::*;
#(
  parameter int unsigned MAX_NODES  = MaxNodesDef,
  parameter int unsigned CATEGORIES = CategoriesDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  kwt_in_if.sink  in_i,
  kwt_out_if.source out_o
);

  localparam int unsigned NodeW = $clog2(MAX_NODES);
  localparam int unsigned SlotW = NodeW + ChW;
  localparam int unsigned RecW  = SlotW + CatW;
  localparam int unsigned CntW  = NodeW + 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StNode = 2'd1;
  localparam logic [1:0] StRes  = 2'd2;

  logic [1:0] state_q, state_d;

  // Input holding register.
  logic            buf_valid_q, buf_valid_d;
  logic            buf_kind_q;
  logic [ChW-1:0]  buf_ch_q;
  logic [CatW-1:0] buf_cat_q;
  logic            buf_last_q;

  // Request in progress.
  logic            w_kind_q, w_kind_d;
  logic [ChW-1:0]  w_ch_q, w_ch_d;
  logic [CatW-1:0] w_cat_q, w_cat_d;
  logic            w_last_q, w_last_d;
  logic [SlotW-1:0] slot_q, slot_d;

  // Walk state.
  logic [NodeW-1:0] cur_q, cur_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [LenW-1:0]  walk_len_q, walk_len_d;
  logic [LenW-1:0]  best_len_q, best_len_d;
  logic [CatW-1:0]  best_cat_q, best_cat_d;
  logic [CatW:0]    pend_q, pend_d;
  logic             walk_done_q, walk_done_d;
  logic             dropped_q, dropped_d;
  logic             open_q, open_d;
  logic             open_kind_q, open_kind_d;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic            o_kind_q, o_kind_d;
  logic            o_found_q, o_found_d;
  logic [LenW-1:0] o_len_q, o_len_d;
  logic [CatW-1:0] o_cat_q, o_cat_d;
  logic            o_full_q, o_full_d;

  // Memory side.
  kwt_mem_ctl_t     mem_ctl;
  logic [SlotW-1:0] child_addr;
  logic [NodeW-1:0] child_wdata, child_rdata;
  logic [NodeW-1:0] node_raddr, node_waddr;
  logic [RecW-1:0]  node_wdata, node_rdata;

  kwt_tables #(
    .MAX_NODES (MAX_NODES),
    .NODE_W    (NodeW),
    .SLOT_W    (SlotW),
    .REC_W     (RecW)
  ) u_tables (
    .clk_i         (clk_i),
    .ctl_i         (mem_ctl),
    .child_addr_i  (child_addr),
    .child_wdata_i (child_wdata),
    .child_rdata_o (child_rdata),
    .node_raddr_i  (node_raddr),
    .node_waddr_i  (node_waddr),
    .node_wdata_i  (node_wdata),
    .node_rdata_o  (node_rdata)
  );

  logic out_free;
  logic dispatch;
  logic accept;

  assign out_free = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = !buf_valid_q || dispatch;

  // Record fields of the node that was read.
  logic [SlotW-1:0] rec_slot;
  logic [CatW-1:0]  rec_term;
  assign rec_slot = node_rdata[RecW-1:CatW];
  assign rec_term = node_rdata[CatW-1:0];

  // Category saturated and coded as a terminal value.
  logic [CatW-1:0] cat_sat, term_code;
  always_comb begin
    cat_sat   = (w_cat_q >= CatW'(CATEGORIES)) ? CatW'(CATEGORIES - 1) : w_cat_q;
    term_code = cat_sat + CatW'(1);
  end

  // Sequencer: dispatch, node record read, update.
  always_comb begin
    logic             mismatch;
    logic [NodeW-1:0] eff_cur;
    logic             eff_dropped, eff_done;
    logic             hit, need_res, clear_all;
    logic [NodeW-1:0] cand;
    logic [LenW-1:0]  bl, wl;
    logic [CatW-1:0]  bc;
    logic [CatW:0]    pn;

    state_d     = state_q;
    w_kind_d    = w_kind_q;
    w_ch_d      = w_ch_q;
    w_cat_d     = w_cat_q;
    w_last_d    = w_last_q;
    slot_d      = slot_q;
    cur_d       = cur_q;
    used_d      = used_q;
    walk_len_d  = walk_len_q;
    best_len_d  = best_len_q;
    best_cat_d  = best_cat_q;
    pend_d      = pend_q;
    walk_done_d = walk_done_q;
    dropped_d   = dropped_q;
    open_d      = open_q;
    open_kind_d = open_kind_q;
    out_valid_d = out_valid_q && !out_o.ready;
    o_kind_d    = o_kind_q;
    o_found_d   = o_found_q;
    o_len_d     = o_len_q;
    o_cat_d     = o_cat_q;
    o_full_d    = o_full_q;

    mem_ctl     = '0;
    child_addr  = slot_q;
    child_wdata = used_q[NodeW-1:0];
    node_raddr  = child_rdata;
    node_waddr  = used_q[NodeW-1:0];
    node_wdata  = {slot_q, CatW'(0)};
    dispatch    = 1'b0;

    mismatch    = open_q && (open_kind_q != buf_kind_q);
    eff_cur     = mismatch ? '0 : cur_q;
    eff_dropped = mismatch ? 1'b0 : dropped_q;
    eff_done    = mismatch ? 1'b0 : walk_done_q;
    hit         = 1'b0;
    need_res    = 1'b0;
    clear_all   = 1'b0;
    cand        = child_rdata;
    bl          = best_len_q;
    bc          = best_cat_q;
    wl          = walk_len_q;
    pn          = pend_q;

    unique case (state_q)
      StIdle: begin
        if (buf_valid_q) begin
          // A request of the other kind abandons the open one.
          if (mismatch) begin
            cur_d       = '0;
            walk_len_d  = '0;
            best_len_d  = '0;
            best_cat_d  = '0;
            pend_d      = '0;
            walk_done_d = 1'b0;
            dropped_d   = 1'b0;
          end
          open_d      = 1'b1;
          open_kind_d = buf_kind_q;
          if (buf_kind_q == KindInsert && eff_dropped) begin
            // Dropped keyword: only its final character reports.
            if (!buf_last_q || out_free) begin
              dispatch = 1'b1;
              if (buf_last_q) begin
                out_valid_d = 1'b1;
                o_kind_d    = KindInsert;
                o_found_d   = 1'b0;
                o_len_d     = '0;
                o_cat_d     = '0;
                o_full_d    = 1'b1;
                clear_all   = 1'b1;
              end
            end else begin
              open_d      = open_q;
              open_kind_d = open_kind_q;
              cur_d       = cur_q;
              walk_len_d  = walk_len_q;
              best_len_d  = best_len_q;
              best_cat_d  = best_cat_q;
              pend_d      = pend_q;
              walk_done_d = walk_done_q;
              dropped_d   = dropped_q;
            end
          end else if (buf_kind_q == KindText && eff_done) begin
            // Rest of a finished text is skipped.
            dispatch = 1'b1;
            if (buf_last_q) begin
              clear_all = 1'b1;
            end
          end else begin
            dispatch         = 1'b1;
            slot_d           = {eff_cur, fold_lower(buf_ch_q)};
            child_addr       = {eff_cur, fold_lower(buf_ch_q)};
            mem_ctl.child_re = 1'b1;
            state_d          = StNode;
          end
          if (dispatch) begin
            w_kind_d = buf_kind_q;
            w_ch_d   = buf_ch_q;
            w_cat_d  = buf_cat_q;
            w_last_d = buf_last_q;
          end
        end
      end

      StNode: begin
        mem_ctl.node_re = 1'b1;
        node_raddr      = child_rdata;
        state_d         = StRes;
      end

      StRes: begin
        hit = (cand != '0) && ({1'b0, cand} < used_q) && (rec_slot == slot_q);
        if (w_kind_q == KindInsert) begin
          need_res = w_last_q;
          if (!need_res || out_free) begin
            state_d = StIdle;
            if (hit) begin
              cur_d = cand;
              if (w_last_q) begin
                mem_ctl.node_we = 1'b1;
                node_waddr      = cand;
                node_wdata      = {rec_slot, term_code};
              end
            end else if (used_q < CntW'(MAX_NODES)) begin
              // Allocate the next free node under this slot.
              mem_ctl.child_we = 1'b1;
              mem_ctl.node_we  = 1'b1;
              node_waddr       = used_q[NodeW-1:0];
              node_wdata       = {slot_q, w_last_q ? term_code : CatW'(0)};
              cur_d            = used_q[NodeW-1:0];
              used_d           = used_q + CntW'(1);
            end else begin
              dropped_d = 1'b1;
            end
            if (w_last_q) begin
              out_valid_d = 1'b1;
              o_kind_d    = KindInsert;
              o_found_d   = 1'b0;
              o_len_d     = '0;
              o_cat_d     = '0;
              o_full_d    = dropped_d;
              clear_all   = 1'b1;
            end
          end
        end else begin
          // A pending terminal is decided by the character after it.
          if (pend_q[CatW] && !is_word(w_ch_q)) begin
            bl = walk_len_q;
            bc = pend_q[CatW-1:0];
          end
          pn = '0;
          // A miss ends the walk; a hit reports only on the final character.
          need_res = 1'b1;
          if (hit) begin
            wl = (walk_len_q < LenCap) ? walk_len_q + LenW'(1) : walk_len_q;
            if (rec_term != '0) begin
              pn = {1'b1, rec_term - CatW'(1)};
            end
            if (w_last_q && pn[CatW]) begin
              bl = wl;
              bc = pn[CatW-1:0];
            end
            need_res = w_last_q;
          end
          if (!need_res || out_free) begin
            state_d    = StIdle;
            best_len_d = bl;
            best_cat_d = bc;
            pend_d     = pn;
            if (hit) begin
              cur_d      = cand;
              walk_len_d = wl;
            end
            if (need_res) begin
              out_valid_d = 1'b1;
              o_kind_d    = KindText;
              o_found_d   = (bl != '0);
              o_len_d     = bl;
              o_cat_d     = (bl != '0) ? bc : '0;
              o_full_d    = 1'b0;
              if (w_last_q) begin
                clear_all = 1'b1;
              end else begin
                walk_done_d = 1'b1;
              end
            end
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    if (clear_all) begin
      cur_d       = '0;
      walk_len_d  = '0;
      best_len_d  = '0;
      best_cat_d  = '0;
      pend_d      = '0;
      walk_done_d = 1'b0;
      dropped_d   = 1'b0;
      open_d      = 1'b0;
    end
  end

  // Input register refills in the cycle it is emptied.
  always_comb begin
    buf_valid_d = buf_valid_q;
    if (dispatch) begin
      buf_valid_d = 1'b0;
    end
    if (accept) begin
      buf_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      buf_valid_q <= 1'b0;
      cur_q       <= '0;
      used_q      <= CntW'(1);
      walk_len_q  <= '0;
      best_len_q  <= '0;
      best_cat_q  <= '0;
      pend_q      <= '0;
      walk_done_q <= 1'b0;
      dropped_q   <= 1'b0;
      open_q      <= 1'b0;
      open_kind_q <= KindInsert;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      buf_valid_q <= buf_valid_d;
      cur_q       <= cur_d;
      used_q      <= used_d;
      walk_len_q  <= walk_len_d;
      best_len_q  <= best_len_d;
      best_cat_q  <= best_cat_d;
      pend_q      <= pend_d;
      walk_done_q <= walk_done_d;
      dropped_q   <= dropped_d;
      open_q      <= open_d;
      open_kind_q <= open_kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_kind_q <= in_i.kind;
      buf_ch_q   <= in_i.ch;
      buf_cat_q  <= in_i.category;
      buf_last_q <= in_i.last;
    end
    w_kind_q <= w_kind_d;
    w_ch_q   <= w_ch_d;
    w_cat_q  <= w_cat_d;
    w_last_q <= w_last_d;
    slot_q   <= slot_d;
    o_kind_q  <= o_kind_d;
    o_found_q <= o_found_d;
    o_len_q   <= o_len_d;
    o_cat_q   <= o_cat_d;
    o_full_q  <= o_full_d;
  end

  // Result channel.
  assign out_o.valid          = out_valid_q;
  assign out_o.result_kind    = o_kind_q;
  assign out_o.found          = o_found_q;
  assign out_o.match_length   = o_len_q;
  assign out_o.match_category = o_cat_q;
  assign out_o.table_full     = o_full_q;

endmodule
